### rtl/mwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwe_pkg;

  // store geometry
  localparam int ADDR_BITS  = 6;
  localparam int WORD_BITS  = 16;
  localparam int WORD_COUNT = 1 << ADDR_BITS;
  localparam int ADDR_LEFT_W = $clog2(ADDR_BITS + 1);
  localparam int DATA_LEFT_W = $clog2(WORD_BITS + 1);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] WORD_ERASED = '1;

  // bus ports
  localparam logic [23:0] PORT_DOUT = 24'hF14001;
  localparam logic [23:0] PORT_DIN  = 24'hF14801;
  localparam logic [23:0] PORT_CS   = 24'hF15001;

  // access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // command opcodes
  localparam logic [1:0] OPC_MISC  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;
  localparam logic [1:0] OPC_ERASE = 2'd3;

  // misc sub-commands from the top two address bits
  localparam logic [1:0] MISC_WDS  = 2'd0;
  localparam logic [1:0] MISC_WRAL = 2'd1;
  localparam logic [1:0] MISC_ERAL = 2'd2;
  localparam logic [1:0] MISC_WEN  = 2'd3;

  // serial sequence state
  typedef enum logic [2:0] {
    SQ_START   = 3'd0,
    SQ_OPHI    = 3'd1,
    SQ_OPLO    = 3'd2,
    SQ_ADDR    = 3'd3,
    SQ_DATA    = 3'd4,
    SQ_READOUT = 3'd5,
    SQ_BUSY    = 3'd6
  } seq_state_t;

  // what follows a completed address or data field
  typedef enum logic [2:0] {
    TG_MISC    = 3'd0,
    TG_WDATA   = 3'd1,
    TG_READOUT = 3'd2,
    TG_ERASE   = 3'd3,
    TG_FILL    = 3'd4,
    TG_WRITE   = 3'd5
  } target_t;

  // handshake controller state
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic run_step;
  } mwe_cmd_t;

endpackage

`default_nettype wire

### rtl/mwe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mwe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/mwe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mwe_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mwe_pkg::mwe_cmd_t cmd,
  input  wire logic            item_op,
  input  wire logic [23:0]     item_address,
  input  wire logic            item_din,
  output logic                 read_bit
);

  localparam int AW = mwe_pkg::ADDR_BITS;
  localparam int WW = mwe_pkg::WORD_BITS;
  localparam int LA = mwe_pkg::ADDR_LEFT_W;
  localparam int LD = mwe_pkg::DATA_LEFT_W;
  localparam int BI = mwe_pkg::BIT_IDX_W;

  // decoded item
  logic is_cs;
  logic is_din_wr;
  logic is_dout_rd;
  logic din;

  // sequence registers
  mwe_pkg::seq_state_t seq_state, seq_state_next;
  logic [1:0]          opcode_bits, opcode_bits_next;
  mwe_pkg::target_t    target, target_next;
  logic                chain, chain_next;
  logic [AW-1:0]       addr_shift, addr_shift_next;
  logic [LA-1:0]       addr_left, addr_left_next;
  logic [WW-1:0]       data_shift, data_shift_next;
  logic [LD-1:0]       data_left, data_left_next;
  logic                wr_allowed, wr_allowed_next;
  logic                out_bit_next;

  // store: ram plus per-word valid bits and a fill value for unwritten words
  logic [WW-1:0]         fill_value;
  logic [mwe_pkg::WORD_COUNT-1:0] valid;
  logic [WW-1:0]         ram_rdata;
  logic [WW-1:0]         word_rd;
  logic                  store_we;
  logic [WW-1:0]         store_wdata;
  logic                  store_fill;
  logic [WW-1:0]         fill_wdata;

  mwe_ram #(
    .WIDTH(WW),
    .DEPTH(mwe_pkg::WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.run_step & store_we),
    .waddr(addr_shift_next),
    .wdata(store_wdata),
    .raddr(addr_shift),
    .rdata(ram_rdata)
  );

  assign word_rd = valid[addr_shift] ? ram_rdata : fill_value;

  // capture and decode the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_cs      <= (item_address == mwe_pkg::PORT_CS);
      is_din_wr  <= (item_address == mwe_pkg::PORT_DIN) && (item_op == mwe_pkg::ACC_WRITE);
      is_dout_rd <= (item_address == mwe_pkg::PORT_DOUT) && (item_op == mwe_pkg::ACC_READ);
      din        <= item_din;
    end
  end

  // one step of the serial protocol
  always_comb begin
    logic [LA-1:0] a_dec;
    logic [LD-1:0] d_dec;
    logic          done;
    seq_state_next   = seq_state;
    opcode_bits_next = opcode_bits;
    target_next      = target;
    chain_next       = chain;
    addr_shift_next  = addr_shift;
    addr_left_next   = addr_left;
    data_shift_next  = data_shift;
    data_left_next   = data_left;
    wr_allowed_next  = wr_allowed;
    out_bit_next     = 1'b0;
    store_we         = 1'b0;
    store_wdata      = data_shift;
    store_fill       = 1'b0;
    fill_wdata       = data_shift;
    done             = 1'b0;
    a_dec = (addr_left != '0) ? addr_left - LA'(1) : addr_left;
    d_dec = (data_left != '0) ? data_left - LD'(1) : data_left;

    if (is_cs) begin
      // chip select restarts the sequence and enables writes
      seq_state_next   = mwe_pkg::SQ_START;
      opcode_bits_next = '0;
      target_next      = mwe_pkg::TG_MISC;
      addr_shift_next  = '0;
      addr_left_next   = LA'(AW);
      data_shift_next  = '0;
      data_left_next   = LD'(WW);
      wr_allowed_next  = 1'b1;
    end else if (is_din_wr) begin
      unique case (seq_state)
        mwe_pkg::SQ_START: begin
          seq_state_next = mwe_pkg::SQ_OPHI;
        end
        mwe_pkg::SQ_OPHI: begin
          opcode_bits_next = {din, 1'b0};
          seq_state_next   = mwe_pkg::SQ_OPLO;
        end
        mwe_pkg::SQ_OPLO: begin
          opcode_bits_next = opcode_bits | {1'b0, din};
          seq_state_next   = mwe_pkg::SQ_ADDR;
          addr_left_next   = LA'(AW);
          addr_shift_next  = '0;
          chain_next       = 1'b1;
          unique case (opcode_bits | {1'b0, din})
            mwe_pkg::OPC_MISC:  target_next = mwe_pkg::TG_MISC;
            mwe_pkg::OPC_WRITE: target_next = mwe_pkg::TG_WDATA;
            mwe_pkg::OPC_READ: begin
              target_next     = mwe_pkg::TG_READOUT;
              chain_next      = 1'b0;
              data_left_next  = LD'(WW);
              data_shift_next = '0;
            end
            default:            target_next = mwe_pkg::TG_ERASE;
          endcase
        end
        mwe_pkg::SQ_ADDR: begin
          addr_shift_next = {addr_shift[AW-2:0], din};
          addr_left_next  = a_dec;
          done            = (a_dec == '0);
        end
        mwe_pkg::SQ_DATA: begin
          data_shift_next = {data_shift[WW-2:0], din};
          data_left_next  = d_dec;
          done            = (d_dec == '0);
        end
        default: begin
          // read-out, busy or unused code: bit taken as a start bit
          seq_state_next = mwe_pkg::SQ_OPHI;
        end
      endcase

      // follow-on action of a completed field
      if (done) begin
        if (!chain) begin
          seq_state_next = mwe_pkg::SQ_READOUT;
        end else begin
          unique case (target)
            mwe_pkg::TG_MISC: begin
              unique case (addr_shift_next[AW-1 -: 2])
                mwe_pkg::MISC_WDS: begin
                  wr_allowed_next = 1'b0;
                  seq_state_next  = mwe_pkg::SQ_START;
                end
                mwe_pkg::MISC_WRAL: begin
                  target_next     = mwe_pkg::TG_FILL;
                  chain_next      = 1'b1;
                  seq_state_next  = mwe_pkg::SQ_DATA;
                  data_left_next  = LD'(WW);
                  data_shift_next = '0;
                end
                mwe_pkg::MISC_ERAL: begin
                  store_fill     = wr_allowed;
                  fill_wdata     = mwe_pkg::WORD_ERASED;
                  seq_state_next = mwe_pkg::SQ_BUSY;
                end
                default: begin
                  wr_allowed_next = 1'b1;
                  seq_state_next  = mwe_pkg::SQ_START;
                end
              endcase
            end
            mwe_pkg::TG_WDATA: begin
              target_next     = mwe_pkg::TG_WRITE;
              chain_next      = 1'b1;
              seq_state_next  = mwe_pkg::SQ_DATA;
              data_left_next  = LD'(WW);
              data_shift_next = '0;
            end
            mwe_pkg::TG_READOUT: begin
              seq_state_next = mwe_pkg::SQ_READOUT;
            end
            mwe_pkg::TG_ERASE: begin
              store_we       = wr_allowed;
              store_wdata    = mwe_pkg::WORD_ERASED;
              seq_state_next = mwe_pkg::SQ_BUSY;
            end
            mwe_pkg::TG_FILL: begin
              store_fill     = wr_allowed;
              fill_wdata     = data_shift_next;
              seq_state_next = mwe_pkg::SQ_BUSY;
            end
            default: begin
              store_we       = wr_allowed;
              store_wdata    = data_shift_next;
              seq_state_next = mwe_pkg::SQ_BUSY;
            end
          endcase
        end
      end
    end else if (is_dout_rd) begin
      // serial data-out
      out_bit_next = 1'b1;
      if (seq_state == mwe_pkg::SQ_BUSY) begin
        seq_state_next = mwe_pkg::SQ_START;
        out_bit_next   = 1'b0;
      end else if (seq_state == mwe_pkg::SQ_READOUT) begin
        data_left_next = d_dec;
        out_bit_next   = word_rd[d_dec[BI-1:0]];
        if (d_dec == '0) begin
          seq_state_next = mwe_pkg::SQ_START;
        end
      end
    end
  end

  // sequence and store control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state   <= mwe_pkg::SQ_START;
      opcode_bits <= '0;
      target      <= mwe_pkg::TG_MISC;
      chain       <= 1'b0;
      addr_shift  <= '0;
      addr_left   <= LA'(AW);
      data_shift  <= '0;
      data_left   <= LD'(WW);
      wr_allowed  <= 1'b0;
      fill_value  <= mwe_pkg::WORD_ERASED;
      valid       <= '0;
    end else if (cmd.run_step) begin
      seq_state   <= seq_state_next;
      opcode_bits <= opcode_bits_next;
      target      <= target_next;
      chain       <= chain_next;
      addr_shift  <= addr_shift_next;
      addr_left   <= addr_left_next;
      data_shift  <= data_shift_next;
      data_left   <= data_left_next;
      wr_allowed  <= wr_allowed_next;
      if (store_fill) begin
        fill_value <= fill_wdata;
        valid      <= '0;
      end else if (store_we) begin
        valid[addr_shift_next] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.run_step) begin
      read_bit <= out_bit_next;
    end
  end

endmodule

`default_nettype wire

### rtl/mwe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mwe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output mwe_pkg::mwe_cmd_t      cmd
);

  mwe_pkg::ctrl_state_t state, state_next;
  logic                 m_tvalid_next;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mwe_pkg::CS_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.run_step  = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      mwe_pkg::CS_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = mwe_pkg::CS_EXEC;
        end
      end
      default: begin
        // run once the output register is free or draining
        if (!m_tvalid || m_tready) begin
          cmd.run_step  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = mwe_pkg::CS_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/microwire_serial_eeprom_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial EEPROM of 64 words by 16 bits, worked through byte bus accesses:
// each input item is one bus access and gives exactly one result item.
// A byte write to the data-in port shifts write bit 0 into a command
// (start bit, 2-bit opcode, 6-bit address, 16 data bits for writes); a byte
// read of the data-out port returns the read word MSB first, 0 once after a
// write or erase, and 1 otherwise. Any access to the chip-select port
// restarts the sequence and enables writes. Every other access returns 0.
// An item is first captured and decoded, then run as a protocol step against
// the word store once the output register is free; one item is in work at a
// time. The result sits in an output register, so the next item is taken
// while it waits. Write-all and erase-all finish in a single step: per-word
// valid bits are cleared and unwritten words read the last fill value.

module microwire_serial_eeprom_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // address [23:0], write_data [31:24]
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // read_data [0], zero [7:1]
);

  mwe_pkg::mwe_cmd_t cmd;
  logic              read_bit;

  mwe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd)
  );

  mwe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item_op     (s_tuser),
    .item_address(s_tdata[23:0]),
    .item_din    (s_tdata[24]),
    .read_bit    (read_bit)
  );

  assign m_tdata = {7'b0, read_bit};

endmodule

`default_nettype wire

### dv/mwe_bus_checker.sv
`timescale 1ns / 1ps

module mwe_bus_checker
  import mwe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,   // address [23:0], write_data [31:24]
  input  wire logic        s_tuser,   // op
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,   // read_data [0], zero [7:1]
  output int               errors,
  output int               pending
);

  // shadow copy of the serial protocol state
  seq_state_t             seq;
  target_t                tgt;
  logic [1:0]             opc;
  logic                   chain;
  logic [ADDR_BITS-1:0]   addr_sr;
  logic [ADDR_LEFT_W-1:0] addr_left;
  logic [WORD_BITS-1:0]   data_sr;
  logic [DATA_LEFT_W-1:0] data_left;
  logic                   wr_en;
  logic [WORD_BITS-1:0]   words [WORD_COUNT];

  // result bytes still owed by the block, oldest first
  logic [7:0] dout_expected [$];
  int         fail_count = 0;
  int         result_idx = 0;

  function automatic void restart_select();
    seq       = SQ_START;
    opc       = OPC_MISC;
    tgt       = TG_MISC;
    addr_sr   = '0;
    addr_left = ADDR_LEFT_W'(ADDR_BITS);
    data_sr   = '0;
    data_left = DATA_LEFT_W'(WORD_BITS);
    wr_en     = 1'b1;
  endfunction

  function automatic void reset_model();
    restart_select();
    chain = 1'b0;
    wr_en = 1'b0;
    for (int i = 0; i < WORD_COUNT; i++) words[i] = WORD_ERASED;
  endfunction

  function automatic void start_addr(target_t t, logic ch);
    tgt       = t;
    chain     = ch;
    seq       = SQ_ADDR;
    addr_left = ADDR_LEFT_W'(ADDR_BITS);
    addr_sr   = '0;
  endfunction

  function automatic void start_data(target_t t);
    tgt       = t;
    chain     = 1'b1;
    seq       = SQ_DATA;
    data_left = DATA_LEFT_W'(WORD_BITS);
    data_sr   = '0;
  endfunction

  function automatic void fill_words(logic [WORD_BITS-1:0] v);
    if (wr_en) begin
      for (int i = 0; i < WORD_COUNT; i++) words[i] = v;
    end
  endfunction

  // action once the address or data field is complete
  function automatic void complete_field();
    if (!chain) begin
      seq = SQ_READOUT;
    end else begin
      case (tgt)
        TG_MISC: begin
          case (addr_sr[ADDR_BITS-1 -: 2])
            MISC_WDS: begin
              wr_en = 1'b0;
              seq   = SQ_START;
            end
            MISC_WRAL: start_data(TG_FILL);
            MISC_ERAL: begin
              fill_words(WORD_ERASED);
              seq = SQ_BUSY;
            end
            default: begin
              wr_en = 1'b1;
              seq   = SQ_START;
            end
          endcase
        end
        TG_WDATA: start_data(TG_WRITE);
        TG_READOUT: seq = SQ_READOUT;
        TG_ERASE: begin
          if (wr_en) words[addr_sr] = WORD_ERASED;
          seq = SQ_BUSY;
        end
        TG_FILL: begin
          fill_words(data_sr);
          seq = SQ_BUSY;
        end
        default: begin
          if (wr_en) words[addr_sr] = data_sr;
          seq = SQ_BUSY;
        end
      endcase
    end
  endfunction

  // one serial bit written to the data-in port
  function automatic void shift_in(logic d);
    case (seq)
      SQ_START: seq = SQ_OPHI;
      SQ_OPHI: begin
        opc = {d, 1'b0};
        seq = SQ_OPLO;
      end
      SQ_OPLO: begin
        opc = {opc[1], d};
        case (opc)
          OPC_MISC:  start_addr(TG_MISC, 1'b1);
          OPC_WRITE: start_addr(TG_WDATA, 1'b1);
          OPC_READ: begin
            start_addr(TG_READOUT, 1'b0);
            data_left = DATA_LEFT_W'(WORD_BITS);
            data_sr   = '0;
          end
          default:   start_addr(TG_ERASE, 1'b1);
        endcase
      end
      SQ_ADDR: begin
        addr_sr = {addr_sr[ADDR_BITS-2:0], d};
        if (addr_left != 0) addr_left--;
        if (addr_left == 0) complete_field();
      end
      SQ_DATA: begin
        data_sr = {data_sr[WORD_BITS-2:0], d};
        if (data_left != 0) data_left--;
        if (data_left == 0) complete_field();
      end
      // read-out, busy and the spare encoding take the bit as a start bit
      default: seq = SQ_OPHI;
    endcase
  endfunction

  // one read of the data-out port
  function automatic logic shift_out();
    logic b;
    b = 1'b1;
    if (seq == SQ_BUSY) begin
      seq = SQ_START;
      b   = 1'b0;
    end else if (seq == SQ_READOUT) begin
      if (data_left != 0) data_left--;
      b = words[addr_sr][data_left[BIT_IDX_W-1:0]];
      if (data_left == 0) seq = SQ_START;
    end
    return b;
  endfunction

  // expected result byte of one bus access
  function automatic logic [7:0] eeprom_bus_access(logic kind, logic [23:0] addr,
                                                   logic [7:0] wdata);
    logic b;
    b = 1'b0;
    if (addr == PORT_CS) begin
      restart_select();
    end else if (kind == ACC_WRITE) begin
      if (addr == PORT_DIN) shift_in(wdata[0]);
    end else if (addr == PORT_DOUT) begin
      b = shift_out();
    end
    return {7'd0, b};
  endfunction

  // compare results, then predict the newly accepted item
  always @(posedge clk) begin
    logic [7:0] want;
    logic       have;
    if (rst) begin
      reset_model();
      dout_expected.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        have = dout_expected.size() != 0;
        want = 8'd0;
        if (have) want = dout_expected.pop_front();
        if (!have || m_tdata !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            if (!have)
              $display("%0t: result %0d unexpected, got %02h", $realtime, result_idx,
                       m_tdata);
            else
              $display("%0t: result %0d expected %02h got %02h", $realtime, result_idx,
                       want, m_tdata);
          end
        end
        result_idx++;
      end
      if (s_tvalid && s_tready)
        dout_expected.push_back(eeprom_bus_access(s_tuser, s_tdata[23:0], s_tdata[31:24]));
    end
    pending <= dout_expected.size();
    errors  <= fail_count;
  end

endmodule

### dv/tb_microwire_serial_eeprom_core.sv
`timescale 1ns / 1ps

module tb_microwire_serial_eeprom_core;
  import mwe_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;   // address [23:0], write_data [31:24]
  logic        s_tuser = 1'b0; // op
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;        // read_data [0], zero [7:1]
  int          errors;
  int          pending;

  // accesses that reach a port, and the window with no idling
  int   port_items = 0;
  logic steady = 1'b0;

  microwire_serial_eeprom_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mwe_bus_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // present one access and hold it until taken
  task automatic bus_access(logic kind, logic [23:0] addr, logic [7:0] wdata);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {wdata, addr};
    steady   <= (port_items >= 300 && port_items < 450);
    if (addr == PORT_CS || (addr == PORT_DIN && kind == ACC_WRITE) ||
        (addr == PORT_DOUT && kind == ACC_READ))
      port_items++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic din_bit(logic d);
    bus_access(ACC_WRITE, PORT_DIN, {7'($urandom), d});
  endtask

  task automatic dout_read();
    bus_access(ACC_READ, PORT_DOUT, 8'($urandom));
  endtask

  task automatic chip_sel();
    bus_access(1'($urandom), PORT_CS, 8'($urandom));
  endtask

  task automatic send_bits(logic [15:0] value, int n);
    for (int i = n - 1; i >= 0; i--) din_bit(value[i]);
  endtask

  // stray accesses; one flipped bit of the data-in address can hit data-out
  task automatic stray_access();
    case ($urandom_range(3))
      0: bus_access(1'($urandom), 24'($urandom), 8'($urandom));
      1: bus_access(ACC_READ, PORT_DIN, 8'($urandom));
      2: bus_access(ACC_WRITE, PORT_DOUT, 8'($urandom));
      default: bus_access(1'($urandom), PORT_DIN ^ (24'd1 << $urandom_range(23)),
                          8'($urandom));
    endcase
  endtask

  // one command sequence with random content, sometimes broken off
  task automatic run_command();
    logic [1:0]  opc;
    logic [5:0]  a;
    logic [15:0] w;
    int          r;
    int          n;
    logic        busy_after;
    if ($urandom_range(99) < 70) chip_sel();
    r = $urandom_range(99);
    if (r < 35) opc = OPC_WRITE;
    else if (r < 65) opc = OPC_READ;
    else if (r < 75) opc = OPC_ERASE;
    else opc = OPC_MISC;
    a = ($urandom_range(99) < 50) ? 6'($urandom_range(7)) : 6'($urandom);
    if (opc == OPC_MISC) begin
      r = $urandom_range(99);
      if (r < 40) a[5:4] = MISC_WEN;
      else if (r < 60) a[5:4] = MISC_WDS;
      else if (r < 80) a[5:4] = MISC_WRAL;
      else a[5:4] = MISC_ERAL;
    end
    w = 16'($urandom);
    din_bit(1'($urandom));
    send_bits({14'd0, opc}, 2);
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if ($urandom_range(99) < 3) stray_access();
      if ($urandom_range(99) < 3) dout_read();
      din_bit(a[i]);
    end
    if ($urandom_range(99) < 5) begin
      chip_sel();
    end else begin
      busy_after = opc == OPC_WRITE || opc == OPC_ERASE ||
                   (opc == OPC_MISC && (a[5:4] == MISC_WRAL || a[5:4] == MISC_ERAL));
      if (opc == OPC_WRITE || (opc == OPC_MISC && a[5:4] == MISC_WRAL))
        send_bits(w, WORD_BITS);
      if (opc == OPC_READ)
        n = ($urandom_range(99) < 75) ? WORD_BITS : $urandom_range(20);
      else if (busy_after)
        n = $urandom_range(2);
      else
        n = $urandom_range(1);
      for (int i = 0; i < n; i++) dout_read();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle port reads, wrong directions and address extremes
    dout_read();
    bus_access(ACC_READ, PORT_DIN, 8'h00);
    bus_access(ACC_WRITE, PORT_DOUT, 8'hFF);
    bus_access(ACC_READ, 24'h000000, 8'h00);
    bus_access(ACC_WRITE, 24'hFFFFFF, 8'hFF);
    bus_access(ACC_READ, 24'hFFFFFF, 8'hFF);
    bus_access(ACC_WRITE, 24'h000000, 8'h00);
    bus_access(ACC_READ, PORT_DOUT ^ 24'h000001, 8'h00);
    // erase-all while writes are still disallowed after reset
    bus_access(ACC_WRITE, PORT_DIN, 8'hFF);
    bus_access(ACC_WRITE, PORT_DIN, 8'hFE);
    bus_access(ACC_WRITE, PORT_DIN, 8'h00);
    send_bits(16'b10_0000, ADDR_BITS);
    // data-in while busy counts as a start bit
    din_bit(1'b1);
    dout_read();
    bus_access(ACC_READ, PORT_CS, 8'h00);
    bus_access(ACC_WRITE, PORT_CS, 8'hFF);
    dout_read();

    while (port_items < 750) begin
      if ($urandom_range(99) < 85) run_command();
      else stray_access();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
rtl/mwe_pkg.sv
rtl/mwe_ram.sv
rtl/mwe_datapath.sv
rtl/mwe_ctrl.sv
rtl/microwire_serial_eeprom_core.sv
dv/mwe_bus_checker.sv
dv/tb_microwire_serial_eeprom_core.sv
